/* sv/h2r_pkg.sv */
// shared constants and types for the hsl to rgb converter
package h2r_pkg;

  localparam int unsigned IN_W  = 16;   // width of hue, saturation, lightness ports
  localparam int unsigned OUT_W = 8;    // width of red, green, blue ports

  localparam logic [OUT_W-1:0] BYTE_MAX = {OUT_W{1'b1}};

  // piecewise segment of one channel over the scaled hue
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

endpackage

/* sv/h2r_front.sv */
// front stages: input clipping, q and p formation, per-channel hue positions
module h2r_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_vld,
  input  logic [h2r_pkg::IN_W-1:0]        hue,
  input  logic [h2r_pkg::IN_W-1:0]        saturation,
  input  logic [h2r_pkg::IN_W-1:0]        lightness,
  output logic                            vld,
  output logic [FRAC_BITS:0]              p,
  output logic [FRAC_BITS:0]              q,
  output logic [FRAC_BITS+2:0]            t_red,
  output logic [FRAC_BITS+2:0]            t_green,
  output logic [FRAC_BITS+2:0]            t_blue
);

  localparam int unsigned V_W = FRAC_BITS + 1;
  localparam int unsigned T_W = FRAC_BITS + 3;
  localparam int unsigned P_W = 2 * V_W;
  localparam int unsigned C_W = (h2r_pkg::IN_W > V_W) ? h2r_pkg::IN_W : V_W;

  localparam logic [C_W-1:0] ONE_C  = C_W'(1) << FRAC_BITS;
  localparam logic [V_W-1:0] HALF_V = V_W'(1) << (FRAC_BITS - 1);
  localparam logic [T_W-1:0] TWO_T  = T_W'(2) << FRAC_BITS;
  localparam logic [T_W-1:0] FOUR_T = T_W'(4) << FRAC_BITS;
  localparam logic [T_W-1:0] SIX_T  = T_W'(6) << FRAC_BITS;

  // stage 1: clipped inputs
  logic                 vld1;
  logic [FRAC_BITS-1:0] h1;
  logic [V_W-1:0]       s1;
  logic [V_W-1:0]       l1;

  logic [C_W-1:0] hue_c, sat_c, lig_c;

  always_comb begin
    hue_c = C_W'(hue);
    sat_c = C_W'(saturation);
    lig_c = C_W'(lightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    h1 <= hue_c[FRAC_BITS-1:0];
    s1 <= (sat_c > ONE_C) ? V_W'(ONE_C) : V_W'(sat_c);
    l1 <= (lig_c > ONE_C) ? V_W'(ONE_C) : V_W'(lig_c);
  end

  // stage 2: l*s product, q/p base terms, scaled hue positions
  logic           vld2;
  logic           lo2;
  logic [P_W-1:0] ls2;
  logic [P_W-1:0] aq2;
  logic [P_W-1:0] ap2;
  logic [T_W-1:0] tr2, tg2, tb2;

  logic [T_W-1:0] h6, tr_raw, tb_raw;
  logic           lo1;

  always_comb begin
    lo1    = (l1 < HALF_V);
    h6     = (T_W'(h1) << 2) + (T_W'(h1) << 1);
    tr_raw = h6 + TWO_T;
    // minus one third, wrapped without leaving the position width
    tb_raw = (h6 >= TWO_T) ? h6 - TWO_T : h6 + FOUR_T;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    lo2 <= lo1;
    ls2 <= P_W'(l1) * P_W'(s1);
    aq2 <= lo1 ? P_W'(l1) : P_W'(l1) + P_W'(s1);
    ap2 <= lo1 ? P_W'(l1) : P_W'(l1) - P_W'(s1);
    tg2 <= h6;
    tr2 <= (tr_raw >= SIX_T) ? tr_raw - SIX_T : tr_raw;
    tb2 <= tb_raw;
  end

  // stage 3: q and p, truncated to the fraction width
  logic [P_W-1:0] q2w, p2w;

  always_comb begin
    q2w = (aq2 << FRAC_BITS) + (lo2 ? ls2 : -ls2);
    p2w = (ap2 << FRAC_BITS) + (lo2 ? -ls2 : ls2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld2;
    end
    q       <= q2w[FRAC_BITS +: V_W];
    p       <= p2w[FRAC_BITS +: V_W];
    t_red   <= tr2;
    t_green <= tg2;
    t_blue  <= tb2;
  end

  a_q_ge_p: assert property (@(posedge clk) disable iff (rst) vld |-> (q >= p))
    else $error("q below p");
  a_q_le_one: assert property (@(posedge clk) disable iff (rst) vld |-> (q <= V_W'(ONE_C)))
    else $error("q above one");

endmodule

/* sv/h2r_channel.sv */
// one color channel: segment select, ramp multiply, byte scaling
module h2r_channel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [FRAC_BITS:0]         p,
  input  logic [FRAC_BITS:0]         q,
  input  logic [FRAC_BITS+2:0]       t,
  output logic                       vld,
  output logic [h2r_pkg::OUT_W-1:0]  level
);

  localparam int unsigned V_W = FRAC_BITS + 1;
  localparam int unsigned T_W = FRAC_BITS + 3;
  localparam int unsigned P_W = 2 * V_W;
  localparam int unsigned B_W = V_W + h2r_pkg::OUT_W;

  localparam logic [T_W-1:0] ONE_T   = T_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0] THREE_T = T_W'(3) << FRAC_BITS;
  localparam logic [T_W-1:0] FOUR_T  = T_W'(4) << FRAC_BITS;

  // stage 1: segment, ramp position, span
  logic                 vld1;
  h2r_pkg::seg_t        seg1;
  logic [V_W-1:0]       d1, f1, p1, q1;
  h2r_pkg::seg_t        seg_c;
  logic [T_W-1:0]       f_c;

  always_comb begin
    if (t < ONE_T) begin
      seg_c = h2r_pkg::SEG_RISE;
      f_c   = t;
    end else if (t < THREE_T) begin
      seg_c = h2r_pkg::SEG_HIGH;
      f_c   = '0;
    end else if (t < FOUR_T) begin
      seg_c = h2r_pkg::SEG_FALL;
      f_c   = FOUR_T - t;
    end else begin
      seg_c = h2r_pkg::SEG_LOW;
      f_c   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    seg1 <= seg_c;
    d1   <= q - p;
    f1   <= f_c[V_W-1:0];
    p1   <= p;
    q1   <= q;
  end

  // stage 2: ramp product
  logic           vld2;
  h2r_pkg::seg_t  seg2;
  logic [P_W-1:0] prod2;
  logic [V_W-1:0] p2, q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    seg2  <= seg1;
    prod2 <= P_W'(d1) * P_W'(f1);
    p2    <= p1;
    q2    <= q1;
  end

  // stage 3: channel value
  logic           vld3;
  logic [V_W-1:0] v3;
  logic [V_W-1:0] v_c;

  always_comb begin
    case (seg2)
      h2r_pkg::SEG_RISE: v_c = p2 + prod2[FRAC_BITS +: V_W];
      h2r_pkg::SEG_FALL: v_c = p2 + prod2[FRAC_BITS +: V_W];
      h2r_pkg::SEG_HIGH: v_c = q2;
      default:           v_c = p2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    v3 <= v_c;
  end

  // stage 4: scale by 255, truncate, saturate
  logic [B_W-1:0] scaled;
  logic [B_W-1:0] byte_c;

  always_comb begin
    scaled = (B_W'(v3) << h2r_pkg::OUT_W) - B_W'(v3);
    byte_c = scaled >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld3;
    end
    level <= (byte_c > B_W'(h2r_pkg::BYTE_MAX)) ? h2r_pkg::BYTE_MAX
                                                : byte_c[h2r_pkg::OUT_W-1:0];
  end

  a_high_is_q: assert property (@(posedge clk) disable iff (rst)
    (vld2 && seg2 == h2r_pkg::SEG_HIGH) |=> (v3 == $past(q2)))
    else $error("flat top segment does not give q");

endmodule

/* sv/hsl_to_rgb_converter.sv */
// top level of the hsl to rgb converter: front stages and three channel pipelines
// a pixel passes through the front stages and then the channel stages before its strobe
// throughput: one pixel per cycle, every cycle; busy stays low
// the result is shown for one cycle only, as the receiver cannot stall
// rst (synchronous) clears the valid bits of every stage; data registers hold junk
// the l*s and ramp multipliers each have their own pipeline stage
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [h2r_pkg::IN_W-1:0]   hue,
  input  logic [h2r_pkg::IN_W-1:0]   saturation,
  input  logic [h2r_pkg::IN_W-1:0]   lightness,
  output logic                       strobe,
  output logic [h2r_pkg::OUT_W-1:0]  red,
  output logic [h2r_pkg::OUT_W-1:0]  green,
  output logic [h2r_pkg::OUT_W-1:0]  blue
);

  // fully pipelined, so a transfer is possible in every cycle
  assign busy = 1'b0;

  logic                 accept;
  logic                 f_vld;
  logic [FRAC_BITS:0]   f_p, f_q;
  logic [FRAC_BITS+2:0] f_tr, f_tg, f_tb;
  logic                 vld_r, vld_g, vld_b;

  assign accept = start & ~busy;

  // q and p from lightness and saturation, hue scaled by six and offset per channel
  h2r_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (accept),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .vld        (f_vld),
    .p          (f_p),
    .q          (f_q),
    .t_red      (f_tr),
    .t_green    (f_tg),
    .t_blue     (f_tb)
  );

  // red sits at hue plus one third, blue at hue minus one third
  h2r_channel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_red (
    .clk    (clk),
    .rst    (rst),
    .in_vld (f_vld),
    .p      (f_p),
    .q      (f_q),
    .t      (f_tr),
    .vld    (vld_r),
    .level  (red)
  );

  h2r_channel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_green (
    .clk    (clk),
    .rst    (rst),
    .in_vld (f_vld),
    .p      (f_p),
    .q      (f_q),
    .t      (f_tg),
    .vld    (vld_g),
    .level  (green)
  );

  h2r_channel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blue (
    .clk    (clk),
    .rst    (rst),
    .in_vld (f_vld),
    .p      (f_p),
    .q      (f_q),
    .t      (f_tb),
    .vld    (vld_b),
    .level  (blue)
  );

  // the three channel pipelines run in lockstep
  assign strobe = vld_g;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vld_r == vld_g) && (vld_b == vld_g))
    else $error("channel pipelines out of step");

endmodule
